@@ design/irs_pkg.sv @@
package irs_pkg;

  // Default configuration of the remap table.
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_VALUE_WIDTH = 40;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_MAP    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_DISORDER  = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_CHK,
    ST_APP_LOAD,
    ST_MAP_CHK,
    ST_MAP_LOAD,
    ST_MAP_CUT,
    ST_MAP_TAIL
  } state_e;

endpackage

@@ design/irs_ram.sv @@
module irs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/irs_cut_unit.sv @@
// Shared cut unit: clips the remaining range [start, stop) at a boundary and
// reports the length of the clipped piece and whether it reaches the stop.
module irs_cut_unit #(
  parameter int VALUE_WIDTH = 40
) (
  input  logic [VALUE_WIDTH:0]   start_i,
  input  logic [VALUE_WIDTH:0]   stop_i,
  input  logic [VALUE_WIDTH:0]   bound_i,
  output logic [VALUE_WIDTH:0]   cut_o,
  output logic [VALUE_WIDTH-1:0] len_o,
  output logic                   reach_o
);

  logic [VALUE_WIDTH:0] diff;

  assign reach_o = (stop_i <= bound_i);
  assign cut_o   = reach_o ? stop_i : bound_i;
  assign diff    = cut_o - start_i;
  assign len_o   = diff[VALUE_WIDTH-1:0];

endmodule

@@ design/interval_remap_splitter_unit.sv @@
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+--------------------------
// request   | func_i, entry_*_i, range_start_i, range_length_i | start_i while busy_o low
// result    | piece_*_o, last_piece_o, status_o              | piece_valid_o, one cycle
//
// A clear or the unused code answers directly from the idle state; an append
// answers from its check state with a full or empty table, else after the load of the previous entry.
// A map request that is empty, overflows or meets an empty table answers from
// the map check; otherwise the walk takes one memory load and up to two cuts
// per entry, one before its base and one inside it, then a tail piece if needed.
// Reset clears the sequencer, the fill count and the strobe, not the table memory.
// The receiver cannot stall: every result is presented for exactly one cycle.
module interval_remap_splitter_unit
  import irs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             func_i,
  input  logic [VALUE_WIDTH-1:0] entry_source_i,
  input  logic [VALUE_WIDTH-1:0] entry_dest_i,
  input  logic [VALUE_WIDTH-1:0] entry_span_i,
  input  logic [VALUE_WIDTH-1:0] range_start_i,
  input  logic [VALUE_WIDTH-1:0] range_length_i,
  output logic                   piece_valid_o,
  output logic [VALUE_WIDTH-1:0] piece_start_o,
  output logic [VALUE_WIDTH-1:0] piece_length_o,
  output logic                   piece_translated_o,
  output logic                   last_piece_o,
  output logic [1:0]             status_o
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RamW = 3 * VALUE_WIDTH;

  // Sequencer and table bookkeeping.
  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;

  // Request operands. The range is kept as [start, stop) with one extra bit so
  // that a range ending exactly at the top of the space is representable.
  logic [VALUE_WIDTH:0]   start_q, start_d;
  logic [VALUE_WIDTH:0]   stop_q, stop_d;
  logic [VALUE_WIDTH-1:0] len_q, len_d;
  logic [VALUE_WIDTH-1:0] esrc_q, esrc_d;
  logic [VALUE_WIDTH-1:0] edst_q, edst_d;
  logic [VALUE_WIDTH-1:0] espan_q, espan_d;

  // The entry currently being walked: its base, end and translation offset.
  logic [VALUE_WIDTH-1:0] src_q, src_d;
  logic [VALUE_WIDTH:0]   end_q, end_d;
  logic [VALUE_WIDTH-1:0] delta_q, delta_d;

  // Result register.
  logic                   pv_q, pv_d;
  logic [VALUE_WIDTH-1:0] ps_q, ps_d;
  logic [VALUE_WIDTH-1:0] pl_q, pl_d;
  logic                   pt_q, pt_d;
  logic                   lp_q, lp_d;
  status_e                st_q, st_d;

  // Table memory: one row holds {destination, source, span}.
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  logic [RamW-1:0]        ram_wdata;
  logic                   ram_re;
  logic [IdxW-1:0]        ram_raddr;
  logic [RamW-1:0]        ram_rdata;
  logic [VALUE_WIDTH-1:0] rd_src, rd_dst, rd_span;

  // Shared cut unit.
  logic [VALUE_WIDTH:0]   cut_bound;
  logic [VALUE_WIDTH:0]   cut_point;
  logic [VALUE_WIDTH-1:0] cut_len;
  logic                   cut_reach;

  logic [VALUE_WIDTH:0]   src_ext;
  logic                   in_gap;
  logic                   in_entry;
  logic [VALUE_WIDTH:0]   prev_end;
  logic [CntW-1:0]        prev_idx;
  logic [CntW-1:0]        next_idx;
  logic [VALUE_WIDTH:0]   tail_len;
  logic                   overflow;

  assign rd_span = ram_rdata[VALUE_WIDTH-1:0];
  assign rd_src  = ram_rdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign rd_dst  = ram_rdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH];

  assign src_ext  = {1'b0, src_q};
  assign in_gap   = (start_q < src_ext);
  assign in_entry = !in_gap && (start_q < end_q);
  // Before an entry the range is cut at its base, inside it at its end.
  assign cut_bound = in_gap ? src_ext : end_q;

  assign prev_end = {1'b0, rd_src} + {1'b0, rd_span};
  assign prev_idx = cnt_q - CntW'(1);
  assign next_idx = idx_q + CntW'(1);
  assign tail_len = stop_q - start_q;
  // The range passes the top of the space when its end exceeds 2^VALUE_WIDTH.
  assign overflow = stop_q[VALUE_WIDTH] && (stop_q[VALUE_WIDTH-1:0] != '0);

  assign ram_waddr = cnt_q[IdxW-1:0];
  assign ram_wdata = {edst_q, esrc_q, espan_q};

  irs_ram #(
    .WIDTH(RamW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  irs_cut_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_cut (
    .start_i(start_q),
    .stop_i (stop_q),
    .bound_i(cut_bound),
    .cut_o  (cut_point),
    .len_o  (cut_len),
    .reach_o(cut_reach)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    start_d   = start_q;
    stop_d    = stop_q;
    len_d     = len_q;
    esrc_d    = esrc_q;
    edst_d    = edst_q;
    espan_d   = espan_q;
    src_d     = src_q;
    end_d     = end_q;
    delta_d   = delta_q;
    pv_d      = 1'b0;
    ps_d      = ps_q;
    pl_d      = pl_q;
    pt_d      = pt_q;
    lp_d      = lp_q;
    st_d      = st_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          start_d = {1'b0, range_start_i};
          stop_d  = {1'b0, range_start_i} + {1'b0, range_length_i};
          len_d   = range_length_i;
          esrc_d  = entry_source_i;
          edst_d  = entry_dest_i;
          espan_d = entry_span_i;
          idx_d   = '0;
          case (func_e'(func_i))
            FUNC_CLEAR: begin
              cnt_d = '0;
              pv_d  = 1'b1;
              ps_d  = '0;
              pl_d  = '0;
              pt_d  = 1'b0;
              lp_d  = 1'b1;
              st_d  = STATUS_OK;
            end
            FUNC_APPEND: begin
              state_d = ST_APP_CHK;
            end
            FUNC_MAP: begin
              state_d = ST_MAP_CHK;
            end
            default: begin
              pv_d = 1'b1;
              ps_d = '0;
              pl_d = '0;
              pt_d = 1'b0;
              lp_d = 1'b1;
              st_d = STATUS_OK;
            end
          endcase
        end
      end

      ST_APP_CHK: begin
        pv_d = 1'b1;
        ps_d = '0;
        pl_d = '0;
        pt_d = 1'b0;
        lp_d = 1'b1;
        st_d = STATUS_OK;
        if (cnt_q >= CntW'(TABLE_DEPTH)) begin
          st_d    = STATUS_FULL;
          state_d = ST_IDLE;
        end else if (cnt_q == '0) begin
          ram_we  = 1'b1;
          cnt_d   = cnt_q + CntW'(1);
          state_d = ST_IDLE;
        end else begin
          // Fetch the previous entry to check the ordering.
          pv_d      = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = prev_idx[IdxW-1:0];
          state_d   = ST_APP_LOAD;
        end
      end

      ST_APP_LOAD: begin
        pv_d    = 1'b1;
        ps_d    = '0;
        pl_d    = '0;
        pt_d    = 1'b0;
        lp_d    = 1'b1;
        state_d = ST_IDLE;
        if ({1'b0, esrc_q} < prev_end) begin
          st_d = STATUS_DISORDER;
        end else begin
          st_d   = STATUS_OK;
          ram_we = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
        end
      end

      ST_MAP_CHK: begin
        pt_d = 1'b0;
        lp_d = 1'b1;
        ps_d = start_q[VALUE_WIDTH-1:0];
        pl_d = len_q;
        st_d = STATUS_OK;
        if (len_q == '0) begin
          pv_d    = 1'b1;
          state_d = ST_IDLE;
        end else if (overflow) begin
          pv_d    = 1'b1;
          st_d    = STATUS_OVERFLOW;
          state_d = ST_IDLE;
        end else if (cnt_q == '0) begin
          // Empty table: the whole range passes through.
          pv_d    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = ST_MAP_LOAD;
        end
      end

      ST_MAP_LOAD: begin
        src_d   = rd_src;
        end_d   = {1'b0, rd_src} + {1'b0, rd_span};
        delta_d = rd_dst - rd_src;
        // Prefetch the following entry while this one is being cut.
        if (next_idx < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = next_idx[IdxW-1:0];
        end
        state_d = ST_MAP_CUT;
      end

      ST_MAP_CUT: begin
        if (in_gap || in_entry) begin
          pv_d    = 1'b1;
          pl_d    = cut_len;
          lp_d    = cut_reach;
          st_d    = STATUS_OK;
          pt_d    = in_entry;
          ps_d    = in_entry ? (start_q[VALUE_WIDTH-1:0] + delta_q)
                             : start_q[VALUE_WIDTH-1:0];
          start_d = cut_point;
        end
        if ((in_gap || in_entry) && cut_reach) begin
          state_d = ST_IDLE;
        end else if (!in_gap) begin
          // This entry is finished; move to the next one or to the tail.
          idx_d   = next_idx;
          state_d = (next_idx == cnt_q) ? ST_MAP_TAIL : ST_MAP_LOAD;
        end
      end

      ST_MAP_TAIL: begin
        pv_d    = 1'b1;
        ps_d    = start_q[VALUE_WIDTH-1:0];
        pl_d    = tail_len[VALUE_WIDTH-1:0];
        pt_d    = 1'b0;
        lp_d    = 1'b1;
        st_d    = STATUS_OK;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    stop_q  <= stop_d;
    len_q   <= len_d;
    esrc_q  <= esrc_d;
    edst_q  <= edst_d;
    espan_q <= espan_d;
    src_q   <= src_d;
    end_q   <= end_d;
    delta_q <= delta_d;
    ps_q    <= ps_d;
    pl_q    <= pl_d;
    pt_q    <= pt_d;
    lp_q    <= lp_d;
    st_q    <= st_d;
  end

  assign busy_o             = (state_q != ST_IDLE);
  assign piece_valid_o      = pv_q;
  assign piece_start_o      = ps_q;
  assign piece_length_o     = pl_q;
  assign piece_translated_o = pt_q;
  assign last_piece_o       = lp_q;
  assign status_o           = st_q;

endmodule

@@ design/irs_checker.sv @@
module irs_checker
  import irs_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   busy_o,
  input logic                   piece_valid_o,
  input logic [VALUE_WIDTH-1:0] piece_length_o,
  input logic                   piece_translated_o,
  input logic                   last_piece_o,
  input logic [1:0]             status_o
);

  // Any status other than success ends the request at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    piece_valid_o && (status_o != STATUS_OK) |-> last_piece_o)
    else $error("non-ok status on a piece that is not the last");

  // A translated piece always covers at least one value and reports success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    piece_valid_o && piece_translated_o |->
      (status_o == STATUS_OK) && (piece_length_o != '0))
    else $error("translated piece is empty or carries an error status");

  // The block only turns idle together with the last result of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> piece_valid_o && last_piece_o)
    else $error("block went idle without a last piece");

  // More pieces follow a non-last piece, so the block must still be busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    piece_valid_o && !last_piece_o |-> busy_o)
    else $error("non-last piece while the block is idle");

endmodule

bind interval_remap_splitter_unit irs_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_irs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .busy_o            (busy_o),
  .piece_valid_o     (piece_valid_o),
  .piece_length_o    (piece_length_o),
  .piece_translated_o(piece_translated_o),
  .last_piece_o      (last_piece_o),
  .status_o          (status_o)
);
